// ===== hdl/swm_pkg.sv =====
// Shared constants, register codes and control types for the square wave mixer.
package swm_pkg;

  // Oscillator count and index width
  localparam int NUM_OSC   = 4;
  localparam int OSC_REGS  = 4;
  localparam int OSC_IDX_W = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;

  // Field widths
  localparam int PERIOD_W   = 24;
  localparam int AMP_W      = 16;
  localparam int OSC_WORD_W = 40;
  localparam int SIDX_W     = 24;
  localparam int ENV_W      = 17;
  localparam int STEP_W     = 17;
  localparam int SUM_W      = 17 + OSC_IDX_W;
  localparam int MAG_W      = 16;
  localparam int P_W        = 32;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = 49;
  localparam int SAMPLE_W   = 16;
  localparam int NARROW_W   = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // Arithmetic constants
  localparam logic [ENV_W-1:0]        ENV_ONE  = ENV_W'(65536);
  localparam logic [MUL_B_W-1:0]      K_WIDE   = MUL_B_W'(32767);
  localparam logic [MUL_B_W-1:0]      K_NARROW = MUL_B_W'(127);
  localparam logic [NARROW_W-1:0]     MID8     = NARROW_W'(128);
  localparam logic [P_W:0]            RND24    = (P_W+1)'(24'hFFFFFF);
  localparam logic signed [SUM_W-1:0] SUM_HI   = SUM_W'(32768);
  localparam logic signed [SUM_W-1:0] SUM_LO   = -SUM_HI;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OSC0 = 3'd0,
    REG_OSC1 = 3'd1,
    REG_OSC2 = 3'd2,
    REG_OSC3 = 3'd3,
    REG_WIDE = 3'd4,
    REG_DAMP = 3'd5,
    REG_LEN  = 3'd6,
    REG_STEP = 3'd7
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_OSC,
    S_MAG,
    S_MUL1,
    S_MUL2,
    S_DONE
  } seq_state_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic                 clear;    // zero all phase counters
    logic                 start;    // zero the accumulator
    logic                 step;     // run one oscillator through the adder
    logic [OSC_IDX_W-1:0] osc_idx;
    logic                 mag_load; // clamp sum, take magnitude and sign
    logic                 mul_env;  // multiplier pass 1: magnitude x envelope
    logic                 mul_k;    // multiplier pass 2: product x scale
  } swm_ctl_t;

endpackage

// ===== hdl/swm_osc_acc.sv =====
// Phase counters and the shared accumulator that sums the oscillators one at a time.
module swm_osc_acc import swm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  swm_ctl_t              ctl,
  input  logic [OSC_WORD_W-1:0] osc_words [NUM_OSC],
  output logic [MAG_W-1:0]      mag,
  output logic                  pos
);

  logic [PERIOD_W-1:0]      phase_r [NUM_OSC];
  logic signed [SUM_W-1:0]  sum_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     pos_r;

  logic [OSC_WORD_W-1:0]    word;
  logic [PERIOD_W-1:0]      period;
  logic [AMP_W-1:0]         amp;
  logic [PERIOD_W-1:0]      ph;
  logic [PERIOD_W:0]        ph_inc;
  logic                     wrap;
  logic                     hi_half;
  logic                     active;
  logic signed [SUM_W-1:0]  amp_ext;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [PERIOD_W-1:0]      ph_nxt;
  logic signed [SUM_W-1:0]  clamped;
  logic signed [SUM_W-1:0]  clamped_neg;

  // Selected oscillator
  assign word    = osc_words[ctl.osc_idx];
  assign period  = word[PERIOD_W-1:0];
  assign amp     = word[OSC_WORD_W-1:PERIOD_W];
  assign ph      = phase_r[ctl.osc_idx];
  assign active  = (period != '0);
  assign amp_ext = {{(SUM_W-AMP_W){amp[AMP_W-1]}}, amp};

  // Square decision and phase advance; a stale phase past the period counts high
  assign ph_inc  = {1'b0, ph} + (PERIOD_W+1)'(1);
  assign wrap    = (ph_inc >= {1'b0, period});
  assign hi_half = (ph >= period) || (ph < (period >> 1));
  assign ph_nxt  = wrap ? '0 : ph_inc[PERIOD_W-1:0];

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.start) begin
      sum_nxt = '0;
    end else if (ctl.step && active) begin
      sum_nxt = hi_half ? (sum_r + amp_ext) : (sum_r - amp_ext);
    end
  end

  // Clamp to [-1, 1]
  always_comb begin
    clamped = sum_r;
    if (sum_r > SUM_HI) begin
      clamped = SUM_HI;
    end else if (sum_r < SUM_LO) begin
      clamped = SUM_LO;
    end
  end
  assign clamped_neg = -clamped;

  // Phase counters
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int n = 0; n < NUM_OSC; n++) begin
        phase_r[n] <= '0;
      end
    end else if (ctl.step && active) begin
      phase_r[ctl.osc_idx] <= ph_nxt;
    end
  end

  // Accumulator and magnitude register
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (ctl.mag_load) begin
      pos_r <= (sum_r > SUM_W'(0));
      mag_r <= (sum_r > SUM_W'(0)) ? clamped[MAG_W-1:0] : clamped_neg[MAG_W-1:0];
    end
  end

  assign mag = mag_r;
  assign pos = pos_r;

endmodule

// ===== hdl/swm_mul_fmt.sv =====
// Shared multiplier for envelope and output scaling, plus the sample format logic.
module swm_mul_fmt import swm_pkg::*; (
  input  logic                clk,
  input  swm_ctl_t            ctl,
  input  logic [MAG_W-1:0]    mag,
  input  logic                pos,
  input  logic [ENV_W-1:0]    env_use,
  input  logic                wide,
  output logic [SAMPLE_W-1:0] result
);

  logic [P_W-1:0]      p_r;
  logic [PROD_W-1:0]   prod_r;
  logic [P_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod;

  logic [SAMPLE_W-1:0] w_pos;
  logic [SAMPLE_W-1:0] w_neg;
  logic [P_W:0]        p_rnd;
  logic [NARROW_W-1:0] n_pos;
  logic [NARROW_W-1:0] n_neg;

  // Operand select: pass 1 magnitude x envelope, pass 2 product x full scale
  assign mul_a = ctl.mul_k ? p_r : P_W'(mag);
  assign mul_b = ctl.mul_k ? (wide ? K_WIDE : K_NARROW) : env_use;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (ctl.mul_env) begin
      p_r <= prod[P_W-1:0];
    end
    if (ctl.mul_k) begin
      prod_r <= prod;
    end
  end

  // 16-bit: positive x 32767, negative x 32768, both toward zero
  assign w_pos = prod_r[46:31];
  assign w_neg = SAMPLE_W'(0) - p_r[31:16];

  // 8-bit offset: 128 + 127x, or 128 - ceil of 128|x|
  assign p_rnd = {1'b0, p_r} + RND24;
  assign n_pos = MID8 + {1'b0, prod_r[38:31]};
  assign n_neg = MID8 - p_rnd[P_W:24];

  always_comb begin
    if (wide) begin
      result = pos ? w_pos : w_neg;
    end else begin
      result = {{(SAMPLE_W-NARROW_W){1'b0}}, (pos ? n_pos : n_neg)};
    end
  end

endmodule

// ===== hdl/swm_seq.sv =====
// Sequencer: steps one sample through the shared units and keeps index and envelope.
module swm_seq import swm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_restart,
  input  logic              out_free,
  input  logic              damping_on,
  input  logic [SIDX_W-1:0] run_length,
  input  logic [STEP_W-1:0] envelope_step,
  output logic              in_ready,
  output swm_ctl_t          ctl,
  output logic [ENV_W-1:0]  env_use,
  output logic              done,
  output logic              last
);

  seq_state_t           state_r, state_nxt;
  logic [OSC_IDX_W-1:0] osc_r, osc_nxt;
  logic [SIDX_W-1:0]    sidx_r, sidx_nxt;
  logic [ENV_W-1:0]     env_r, env_nxt;
  logic [SIDX_W-1:0]    len_m1;
  logic [ENV_W-1:0]     env_dec;

  // End of run test; a zero length acts as one
  assign len_m1  = (run_length == '0) ? '0 : (run_length - SIDX_W'(1));
  assign last    = (sidx_r >= len_m1);
  assign env_use = damping_on ? env_r : ENV_ONE;
  assign env_dec = (env_r > envelope_step) ? (env_r - envelope_step) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      osc_r   <= '0;
      sidx_r  <= '0;
      env_r   <= ENV_ONE;
    end else begin
      state_r <= state_nxt;
      osc_r   <= osc_nxt;
      sidx_r  <= sidx_nxt;
      env_r   <= env_nxt;
    end
  end

  // Next state and controls
  always_comb begin
    state_nxt = state_r;
    osc_nxt   = osc_r;
    sidx_nxt  = sidx_r;
    env_nxt   = env_r;
    ctl       = '0;
    in_ready  = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // no word is taken while reset is held
        in_ready = rst_n;
        if (in_valid) begin
          ctl.start = 1'b1;
          ctl.clear = in_restart;
          osc_nxt   = '0;
          state_nxt = S_OSC;
          if (in_restart) begin
            sidx_nxt = '0;
            env_nxt  = ENV_ONE;
          end
        end
      end
      S_OSC: begin
        ctl.step    = 1'b1;
        ctl.osc_idx = osc_r;
        if (osc_r == OSC_IDX_W'(NUM_OSC - 1)) begin
          state_nxt = S_MAG;
        end else begin
          osc_nxt = osc_r + OSC_IDX_W'(1);
        end
      end
      S_MAG: begin
        ctl.mag_load = 1'b1;
        state_nxt    = S_MUL1;
      end
      S_MUL1: begin
        ctl.mul_env = 1'b1;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        ctl.mul_k = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for a free output slot, then retire the sample
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
          if (damping_on) begin
            env_nxt = env_dec;
          end
          if (last) begin
            ctl.clear = 1'b1;
            sidx_nxt  = '0;
            env_nxt   = ENV_ONE;
          end else begin
            sidx_nxt = sidx_r + SIDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/square_wave_mixer_synth_top.sv =====
// Square wave mixer synthesizer top level. Each input word asks for one PCM sample: the
// sum of NUM_OSC square oscillators, clamped to full scale, optionally scaled by a linearly
// falling envelope, and sent out as signed 16-bit or offset 8-bit. A sample runs through
// these steps in order: acceptance, one step per oscillator through the shared adder, a
// clamp step, two passes through the shared multiplier and a format step, which writes the
// word into the output register; the input is not ready meanwhile. The output register
// holds a finished word so the next sample can start while it waits to be taken; the format
// step waits while that register is still full. Configuration is written through a
// simple indexed write port.
module square_wave_mixer_synth_top import swm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_restart,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_last,
  // configuration port
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  logic [OSC_WORD_W-1:0] osc_word_r [NUM_OSC];
  logic                  wide_r;
  logic                  damp_r;
  logic [SIDX_W-1:0]     len_r;
  logic [STEP_W-1:0]     step_r;

  logic                  out_valid_r;
  logic [SAMPLE_W-1:0]   out_sample_r;
  logic                  out_last_r;

  swm_ctl_t              ctl;
  logic [ENV_W-1:0]      env_use;
  logic                  done;
  logic                  last;
  logic                  out_free;
  logic [MAG_W-1:0]      mag;
  logic                  pos;
  logic [SAMPLE_W-1:0]   result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NUM_OSC; n++) begin
        osc_word_r[n] <= '0;
      end
      wide_r <= 1'b1;
      damp_r <= 1'b0;
      len_r  <= SIDX_W'(1);
      step_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index) inside
        REG_OSC0, REG_OSC1, REG_OSC2, REG_OSC3: begin
          // words for oscillators beyond NUM_OSC are dropped
          if (32'(cfg_index) < NUM_OSC) begin
            osc_word_r[cfg_index[OSC_IDX_W-1:0]] <= cfg_wdata[OSC_WORD_W-1:0];
          end
        end
        REG_WIDE: wide_r <= cfg_wdata[0];
        REG_DAMP: damp_r <= cfg_wdata[0];
        REG_LEN:  len_r  <= cfg_wdata[SIDX_W-1:0];
        REG_STEP: step_r <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;

  swm_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_restart    (in_restart),
    .out_free      (out_free),
    .damping_on    (damp_r),
    .run_length    (len_r),
    .envelope_step (step_r),
    .in_ready      (in_ready),
    .ctl           (ctl),
    .env_use       (env_use),
    .done          (done),
    .last          (last)
  );

  swm_osc_acc u_osc_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .osc_words (osc_word_r),
    .mag       (mag),
    .pos       (pos)
  );

  swm_mul_fmt u_mul_fmt (
    .clk     (clk),
    .ctl     (ctl),
    .mag     (mag),
    .pos     (pos),
    .env_use (env_use),
    .wide    (wide_r),
    .result  (result)
  );

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_sample_r <= result;
      out_last_r   <= last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule
